>>> hdl/atfb_pkg.sv
// types, constants and register indexes for the transmit-request frame builder
// no dependencies; imported by every module of the block
`default_nettype none

package atfb_pkg;

    // payload limits
    localparam int MAX_PAYLOAD = 256;
    localparam int LEN_W       = 9;

    // fixed frame bytes
    localparam logic [7:0] START_DELIM  = 8'h7E;
    localparam logic [7:0] FRAME_TYPE   = 8'h10;
    localparam logic [7:0] HEADER_EXTRA = 8'd14;
    localparam logic [7:0] SUM_BASE     = 8'hFF;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ID   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_NET   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TX_OPTIONS = 3'd5;

    // register reset values
    localparam logic [7:0]  RST_FRAME_ID   = 8'h01;
    localparam logic [31:0] RST_DEST_HIGH  = 32'h0013A200;
    localparam logic [31:0] RST_DEST_LOW   = 32'h0;
    localparam logic [15:0] RST_DEST_NET   = 16'hFFFE;
    localparam logic [7:0]  RST_RADIUS     = 8'h00;
    localparam logic [7:0]  RST_TX_OPTIONS = 8'h00;

    // byte positions within one frame
    localparam int POS_W = 5;
    localparam logic [POS_W-1:0] POS_DELIM    = 5'd0;
    localparam logic [POS_W-1:0] POS_LEN_HI   = 5'd1;
    localparam logic [POS_W-1:0] POS_LEN_LO   = 5'd2;
    localparam logic [POS_W-1:0] POS_TYPE     = 5'd3;
    localparam logic [POS_W-1:0] POS_ID       = 5'd4;
    localparam logic [POS_W-1:0] POS_HIGH3    = 5'd5;
    localparam logic [POS_W-1:0] POS_HIGH2    = 5'd6;
    localparam logic [POS_W-1:0] POS_HIGH1    = 5'd7;
    localparam logic [POS_W-1:0] POS_HIGH0    = 5'd8;
    localparam logic [POS_W-1:0] POS_LOW3     = 5'd9;
    localparam logic [POS_W-1:0] POS_LOW2     = 5'd10;
    localparam logic [POS_W-1:0] POS_LOW1     = 5'd11;
    localparam logic [POS_W-1:0] POS_LOW0     = 5'd12;
    localparam logic [POS_W-1:0] POS_NET_HI   = 5'd13;
    localparam logic [POS_W-1:0] POS_NET_LO   = 5'd14;
    localparam logic [POS_W-1:0] POS_RADIUS   = 5'd15;
    localparam logic [POS_W-1:0] POS_OPTIONS  = 5'd16;
    localparam logic [POS_W-1:0] POS_PAYLOAD  = 5'd17;
    localparam logic [POS_W-1:0] POS_CHECKSUM = 5'd18;

    // queue depth
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0]       payload_byte;
        logic [LEN_W-1:0] payload_length;
    } in_item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  frame_id;
        logic [31:0] dest_addr_high;
        logic [31:0] dest_addr_low;
        logic [15:0] dest_net_addr;
        logic [7:0]  radius;
        logic [7:0]  tx_options;
    } cfg_t;

    // classified word handed from front to back
    typedef struct packed {
        logic [7:0]       payload_byte;
        logic [LEN_W-1:0] length;
        logic             first;
        logic             last;
    } qentry_t;

endpackage

`default_nettype wire

>>> hdl/atfb_front.sv
// front end: accepts payload words, tracks frame position, classifies first/last
// depends on atfb_pkg
`default_nettype none

module atfb_front
    import atfb_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    input  wire logic     q_full,
    output logic          q_push,
    output qentry_t       q_entry
);

    logic [LEN_W-1:0] bytes_left_reg;
    logic [LEN_W-1:0] bytes_left_next;
    logic [LEN_W-1:0] len_clamped;
    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] remain;
    logic             starting;

    // clamp the requested length to one..MAX_PAYLOAD
    always_comb begin
        if (s_data.payload_length == '0) begin
            len_clamped = LEN_W'(1);
        end else if (s_data.payload_length > LEN_W'(MAX_PAYLOAD)) begin
            len_clamped = LEN_W'(MAX_PAYLOAD);
        end else begin
            len_clamped = s_data.payload_length;
        end
    end

    // classify the word
    always_comb begin
        starting              = (bytes_left_reg == '0);
        len_eff               = starting ? len_clamped : bytes_left_reg;
        remain                = len_eff - LEN_W'(1);
        s_ready               = !q_full;
        q_push                = s_valid && s_ready;
        q_entry.payload_byte  = s_data.payload_byte;
        q_entry.length        = len_clamped;
        q_entry.first         = starting;
        q_entry.last          = (remain == '0);
        bytes_left_next       = q_push ? remain : bytes_left_reg;
    end

    // frame position counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= '0;
        end else begin
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/atfb_queue.sv
// short queue between front and back ends
// depends on atfb_pkg
`default_nettype none

module atfb_queue
    import atfb_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire qentry_t push_entry,
    output logic         full,
    input  wire logic    pop,
    output logic         head_valid,
    output qentry_t      head
);

    qentry_t           slots_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    // occupancy and pointers
    always_comb begin
        full        = (count_reg == (QPTR_W+1)'(QDEPTH));
        head_valid  = (count_reg != '0);
        head        = slots_reg[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

>>> hdl/atfb_back.sv
// back end: sequences header, payload and checksum bytes into the output register
// depends on atfb_pkg
`default_nettype none

module atfb_back
    import atfb_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire cfg_t    cfg,
    input  wire logic    head_valid,
    input  wire qentry_t head,
    output logic         pop,
    output logic         m_valid,
    input  wire logic    m_ready,
    output out_item_t    m_data
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             busy_reg;
    logic             busy_next;
    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    out_item_t        m_data_reg;
    out_item_t        m_data_next;
    logic [POS_W-1:0] pos_cur;
    logic [15:0]      total;
    logic [7:0]       byte_sel;
    logic             step;
    logic             done;

    // current position within the frame
    always_comb begin
        if (busy_reg) begin
            pos_cur = pos_reg;
        end else if (head.first) begin
            pos_cur = POS_DELIM;
        end else begin
            pos_cur = POS_PAYLOAD;
        end
        total = 16'(head.length) + 16'(HEADER_EXTRA);
    end

    // byte selection
    always_comb begin
        case (pos_cur)
            POS_DELIM:    byte_sel = START_DELIM;
            POS_LEN_HI:   byte_sel = total[15:8];
            POS_LEN_LO:   byte_sel = total[7:0];
            POS_TYPE:     byte_sel = FRAME_TYPE;
            POS_ID:       byte_sel = cfg.frame_id;
            POS_HIGH3:    byte_sel = cfg.dest_addr_high[31:24];
            POS_HIGH2:    byte_sel = cfg.dest_addr_high[23:16];
            POS_HIGH1:    byte_sel = cfg.dest_addr_high[15:8];
            POS_HIGH0:    byte_sel = cfg.dest_addr_high[7:0];
            POS_LOW3:     byte_sel = cfg.dest_addr_low[31:24];
            POS_LOW2:     byte_sel = cfg.dest_addr_low[23:16];
            POS_LOW1:     byte_sel = cfg.dest_addr_low[15:8];
            POS_LOW0:     byte_sel = cfg.dest_addr_low[7:0];
            POS_NET_HI:   byte_sel = cfg.dest_net_addr[15:8];
            POS_NET_LO:   byte_sel = cfg.dest_net_addr[7:0];
            POS_RADIUS:   byte_sel = cfg.radius;
            POS_OPTIONS:  byte_sel = cfg.tx_options;
            POS_PAYLOAD:  byte_sel = head.payload_byte;
            POS_CHECKSUM: byte_sel = SUM_BASE - sum_reg;
            default:      byte_sel = '0;
        endcase
    end

    // sequencing and checksum accumulation
    always_comb begin
        step = head_valid && (!m_valid_reg || m_ready);
        done = (pos_cur == POS_CHECKSUM) || ((pos_cur == POS_PAYLOAD) && !head.last);
        pop  = step && done;

        pos_next  = pos_reg;
        busy_next = busy_reg;
        sum_next  = sum_reg;
        if (step) begin
            pos_next  = pos_cur + POS_W'(1);
            busy_next = !done;
            if (pos_cur == POS_TYPE) begin
                sum_next = byte_sel;
            end else if (pos_cur > POS_TYPE && pos_cur <= POS_PAYLOAD) begin
                sum_next = sum_reg + byte_sel;
            end
        end

        m_data_next = m_data_reg;
        if (step) begin
            m_valid_next           = 1'b1;
            m_data_next.frame_byte = byte_sel;
            m_data_next.frame_end  = (pos_cur == POS_CHECKSUM);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end

        m_valid = m_valid_reg;
        m_data  = m_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            busy_reg    <= 1'b0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            busy_reg    <= busy_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    // checksum only follows the last payload word of a frame
    a_checksum_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && pos_cur == POS_CHECKSUM) |-> head.last)
        else $error("checksum emitted for a word that is not last");

    // a word in progress stays at the queue head
    a_busy_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> head_valid)
        else $error("sequencer busy with empty queue");

    // sequencer never runs past the checksum
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (pos_reg <= POS_CHECKSUM))
        else $error("frame position out of range");

    // frame end on the output follows a checksum step
    a_end_from_checksum: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && pos_cur != POS_CHECKSUM) |=> !m_data_reg.frame_end)
        else $error("frame end flagged on a non-checksum byte");

endmodule

`default_nettype wire

>>> hdl/api_transmit_frame_builder_unit.sv
// Transmit-request frame builder. Each accepted s_ word carries one payload byte;
// the first word of a frame also sets the payload length (0 is taken as 1, above
// 256 as 256). The first word produces 18 output bytes in a row (start delimiter,
// 16-bit length, frame type, frame id, 64-bit and 16-bit destination, radius,
// options, then the payload byte); middle words produce one byte; the last word
// adds the checksum byte, flagged by frame_end. The output sequencer emits one
// byte per cycle while m_ready allows, so payload words flow at one per cycle
// while a four-entry queue takes input during the header burst. Registers are set
// through cfg_we/cfg_index/cfg_data and must be written between frames.
// depends on atfb_pkg, atfb_front, atfb_queue, atfb_back
`default_nettype none

module api_transmit_frame_builder_unit
    import atfb_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    q_full;
    logic    q_push;
    qentry_t q_entry;
    logic    q_pop;
    logic    q_head_valid;
    qentry_t q_head;

    // configuration register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_FRAME_ID:   cfg_next.frame_id       = cfg_data[7:0];
                REG_DEST_HIGH:  cfg_next.dest_addr_high = cfg_data;
                REG_DEST_LOW:   cfg_next.dest_addr_low  = cfg_data;
                REG_DEST_NET:   cfg_next.dest_net_addr  = cfg_data[15:0];
                REG_RADIUS:     cfg_next.radius         = cfg_data[7:0];
                REG_TX_OPTIONS: cfg_next.tx_options     = cfg_data[7:0];
                default:        cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_id       <= RST_FRAME_ID;
            cfg_reg.dest_addr_high <= RST_DEST_HIGH;
            cfg_reg.dest_addr_low  <= RST_DEST_LOW;
            cfg_reg.dest_net_addr  <= RST_DEST_NET;
            cfg_reg.radius         <= RST_RADIUS;
            cfg_reg.tx_options     <= RST_TX_OPTIONS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    atfb_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    atfb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    atfb_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire
